### rtl/assert_macros.svh
// assertion helpers used by the engine core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, skipped while in reset
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// same, but also checked while reset is asserted
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

### rtl/lnee_pkg.sv
package lnee_pkg;

    localparam int NETS_DEF  = 4096;
    localparam int LANES_DEF = 32;

    localparam int DATA_W  = 32;
    localparam int NET_W   = 12;
    localparam int TT_W    = 16;
    localparam int ICNT_W  = 3;
    localparam int CNT_W   = 13;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CNT_W-1:0] NETS_USED_RST = 13'd4096;
    localparam logic [ICNT_W-1:0] LUT_INPUTS   = 3'd4;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_LUT   = 2'd2;
    localparam logic [1:0] OP_FF    = 2'd3;

    localparam logic REG_NETS_USED = 1'b0;

    typedef struct packed {
        logic [1:0]        op;
        logic [NET_W-1:0]  net;
        logic [DATA_W-1:0] value;
        logic [TT_W-1:0]   lut_bits;
        logic [ICNT_W-1:0] input_count;
        logic [NET_W-1:0]  in_a;
        logic [NET_W-1:0]  in_b;
        logic [NET_W-1:0]  in_c;
        logic [NET_W-1:0]  in_d;
    } req_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              in_range;
    } rsp_item_t;

endpackage

### rtl/lut4_net_evaluation_engine_core.sv
// channel   | signals                         | payload
// ----------+---------------------------------+---------------------------------
// request   | req_valid / req_ready           | req (lnee_pkg::req_item_t)
// response  | rsp_valid / rsp_ready           | rsp (lnee_pkg::rsp_item_t)
// config    | psel penable pwrite paddr pwdata| prdata, pready tied high
//
// after reset a clearing pass writes zero to all NETS entries (4096 by default) before
// the first request transfer; config writes are taken meanwhile. one item at a time goes
// through the single-port-read net store: a write goes straight to execute, while read,
// flip-flop and lut read operands first (one store read issued per cycle, 4 reads for lut).
// a finished result sits in the response register; the next request is taken
// while it waits, and the engine stalls only when a second result is ready.
`include "assert_macros.svh"

module lut4_net_evaluation_engine_core #(
    parameter int NETS  = lnee_pkg::NETS_DEF,
    parameter int LANES = lnee_pkg::LANES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  lnee_pkg::req_item_t            req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output lnee_pkg::rsp_item_t            rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lnee_pkg::PADDR_W-1:0]   paddr,
    input  logic [lnee_pkg::PDATA_W-1:0]   pwdata,
    output logic [lnee_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    localparam int AW = $clog2(NETS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NETS - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EXEC  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [lnee_pkg::CNT_W-1:0] nets_used_reg, nets_used_next;

    // latched item
    logic [1:0]                    op_reg, op_next;
    logic [lnee_pkg::NET_W-1:0]    tgt_reg, tgt_next;
    logic [lnee_pkg::DATA_W-1:0]   val_reg, val_next;
    logic [lnee_pkg::TT_W-1:0]     tt_reg, tt_next;
    logic [lnee_pkg::NET_W-1:0]    src_reg [4];
    logic [lnee_pkg::NET_W-1:0]    src_next [4];
    logic [2:0]                    nrd_reg, nrd_next;

    // operand fetch
    logic [2:0]       rd_cnt_reg, rd_cnt_next;
    logic             pend_reg, pend_next;
    logic [1:0]       pend_idx_reg, pend_idx_next;
    logic             pend_ok_reg, pend_ok_next;
    logic [LANES-1:0] opnd_reg [4];
    logic [LANES-1:0] opnd_next [4];

    logic                rsp_valid_reg, rsp_valid_next;
    lnee_pkg::rsp_item_t rsp_reg, rsp_next;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [LANES-1:0] ram_wdata, ram_rdata;

    logic [LANES-1:0] lut_y;
    logic [LANES-1:0] result;
    logic             tgt_ok;
    logic             out_load;
    logic             cfg_wr;
    logic [2:0]       icnt;
    logic [lnee_pkg::NET_W-1:0] pad;
    logic [lnee_pkg::NET_W-1:0] ids [4];
    logic [lnee_pkg::NET_W-1:0] iss_src;

    function automatic logic id_ok(
        input logic [lnee_pkg::NET_W-1:0] id,
        input logic [lnee_pkg::CNT_W-1:0] cnt
    );
        return (32'(id) < 32'(cnt)) && (32'(id) < 32'(NETS));
    endfunction

    lnee_ram #(
        .WIDTH (LANES),
        .DEPTH (NETS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lnee_lut #(
        .LANES (LANES)
    ) u_lut (
        .lut_bits    (tt_reg),
        .a           (opnd_reg[0]),
        .b           (opnd_reg[1]),
        .c           (opnd_reg[2]),
        .d           (opnd_reg[3]),
        .y           (lut_y)
    );

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign prdata    = (paddr[2] == lnee_pkg::REG_NETS_USED)
                       ? lnee_pkg::PDATA_W'(nets_used_reg) : '0;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign tgt_ok   = id_ok(tgt_reg, nets_used_reg);
    assign out_load = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign iss_src  = src_reg[rd_cnt_reg[1:0]];

    // lut input selection with padding
    assign icnt   = (req.input_count > lnee_pkg::LUT_INPUTS) ? lnee_pkg::LUT_INPUTS
                                                             : req.input_count;
    assign pad    = (icnt == 3'd0) ? '0 : req.in_a;
    assign ids[0] = req.in_a;
    assign ids[1] = req.in_b;
    assign ids[2] = req.in_c;
    assign ids[3] = req.in_d;

    always_comb
    begin
        case (op_reg)
            lnee_pkg::OP_WRITE: result = LANES'(val_reg);
            lnee_pkg::OP_LUT:   result = lut_y;
            default:            result = opnd_reg[0];
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        nets_used_next = nets_used_reg;
        op_next        = op_reg;
        tgt_next       = tgt_reg;
        val_next       = val_reg;
        tt_next        = tt_reg;
        nrd_next       = nrd_reg;
        rd_cnt_next    = rd_cnt_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        pend_ok_next   = pend_ok_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        for (int i = 0; i < 4; i++)
        begin
            src_next[i]  = src_reg[i];
            opnd_next[i] = opnd_reg[i];
        end
        ram_we    = 1'b0;
        ram_waddr = AW'(tgt_reg);
        ram_wdata = result;
        ram_re    = 1'b0;
        ram_raddr = AW'(iss_src);

        if (cfg_wr && (paddr[2] == lnee_pkg::REG_NETS_USED))
        begin
            nets_used_next = pwdata[lnee_pkg::CNT_W-1:0];
        end

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.op;
                    tgt_next    = req.net;
                    val_next    = req.value;
                    tt_next     = req.lut_bits;
                    rd_cnt_next = '0;
                    for (int i = 0; i < 4; i++)
                    begin
                        src_next[i] = (3'(i) < icnt) ? ids[i] : pad;
                    end
                    case (req.op)
                        lnee_pkg::OP_WRITE:
                        begin
                            nrd_next   = 3'd0;
                            state_next = ST_EXEC;
                        end
                        lnee_pkg::OP_READ:
                        begin
                            nrd_next    = 3'd1;
                            src_next[0] = req.net;
                            state_next  = ST_READ;
                        end
                        lnee_pkg::OP_LUT:
                        begin
                            nrd_next   = 3'd4;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            nrd_next    = 3'd1;
                            src_next[0] = req.in_a;
                            state_next  = ST_READ;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // one store read issued per cycle, its data captured in the cycle after issue
                if (rd_cnt_reg < nrd_reg)
                begin
                    ram_re        = 1'b1;
                    rd_cnt_next   = rd_cnt_reg + 3'd1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_cnt_reg[1:0];
                    pend_ok_next  = id_ok(iss_src, nets_used_reg);
                end
                if (pend_reg)
                begin
                    opnd_next[pend_idx_reg] = pend_ok_reg ? ram_rdata : '0;
                    if (rd_cnt_reg == nrd_reg)
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                if (out_load)
                begin
                    // store write lands before the next item can issue a read
                    ram_we         = tgt_ok && (op_reg != lnee_pkg::OP_READ);
                    rsp_valid_next = 1'b1;
                    rsp_next.data  = lnee_pkg::DATA_W'(result);
                    rsp_next.in_range = tgt_ok;
                    if ((op_reg == lnee_pkg::OP_READ) && !tgt_ok)
                    begin
                        rsp_next.data = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            nets_used_reg <= lnee_pkg::NETS_USED_RST;
            rd_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            nets_used_reg <= nets_used_next;
            rd_cnt_reg    <= rd_cnt_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        tgt_reg      <= tgt_next;
        val_reg      <= val_next;
        tt_reg       <= tt_next;
        nrd_reg      <= nrd_next;
        pend_idx_reg <= pend_idx_next;
        pend_ok_reg  <= pend_ok_next;
        rsp_reg      <= rsp_next;
        for (int i = 0; i < 4; i++)
        begin
            src_reg[i]  <= src_next[i];
            opnd_reg[i] <= opnd_next[i];
        end
    end

    `ASSERT_CLK(a_no_req_in_clear, clk, rst_n,
        (state_reg == ST_CLEAR) |-> !req_ready,
        "request taken during clearing pass")

    `ASSERT_CLK(a_store_write_phase, clk, rst_n,
        ram_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_EXEC)),
        "store written outside clear or execute")

    `ASSERT_CLK(a_read_count_bound, clk, rst_n,
        (state_reg == ST_READ) |-> (rd_cnt_reg <= nrd_reg),
        "more operand reads issued than needed")

    `ASSERT_CLK(a_rsp_from_exec, clk, rst_n,
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_EXEC),
        "response appeared without an executed item")

    `ASSERT_CLK(a_exec_done, clk, rst_n,
        out_load |=> (state_reg == ST_IDLE),
        "engine did not return to idle after result")

endmodule

### rtl/lnee_ram.sv
module lnee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lnee_lut.sv
module lnee_lut #(
    parameter int LANES = lnee_pkg::LANES_DEF
) (
    input  logic [lnee_pkg::TT_W-1:0] lut_bits,
    input  logic [LANES-1:0]          a,
    input  logic [LANES-1:0]          b,
    input  logic [LANES-1:0]          c,
    input  logic [LANES-1:0]          d,
    output logic [LANES-1:0]          y
);

    // one 16:1 select per lane, lanes independent
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            y[k] = lut_bits[{d[k], c[k], b[k], a[k]}];
        end
    end

endmodule

### verif/lnee_net_checker.sv
`timescale 1ns / 1ps

module lnee_net_checker
    import lnee_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  req_item_t           req,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  rsp_item_t           rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output int unsigned         errors,
    output int unsigned         pending
);

    localparam int NETS = NETS_DEF;
    localparam logic [PADDR_W-1:0] NETS_USED_ADDR = PADDR_W'(4 * int'(REG_NETS_USED));

    logic [DATA_W-1:0] net_shadow [NETS];
    logic [CNT_W-1:0]  nets_used;
    rsp_item_t         rsp_due [$];

    function automatic int nets_in_use();
        return (nets_used > NETS) ? NETS : int'(nets_used);
    endfunction

    function automatic logic [DATA_W-1:0] fetch_net(logic [NET_W-1:0] id);
        if (id < nets_in_use())
            return net_shadow[id];
        return '0;
    endfunction

    // applies one item to the shadow store and returns what the engine must answer
    function automatic rsp_item_t eval_net_item(req_item_t it);
        rsp_item_t         res;
        logic [NET_W-1:0]  given [4];
        logic [NET_W-1:0]  src [4];
        logic [DATA_W-1:0] lane_in [4];
        int unsigned       used;
        logic [3:0]        sel;

        given = '{it.in_a, it.in_b, it.in_c, it.in_d};
        res.in_range = (it.net < nets_in_use());
        res.data = '0;
        case (it.op)
            OP_WRITE: res.data = it.value;
            OP_READ:  res.data = fetch_net(it.net);
            OP_LUT:
            begin
                used = 32'((it.input_count > LUT_INPUTS) ? LUT_INPUTS : it.input_count);
                // missing inputs repeat input a, or net 0 when none are given
                for (int i = 0; i < 4; i++)
                begin
                    if (i < used)
                        src[i] = given[i];
                    else
                        src[i] = (used == 0) ? '0 : it.in_a;
                    lane_in[i] = fetch_net(src[i]);
                end
                for (int k = 0; k < DATA_W; k++)
                begin
                    sel = {lane_in[3][k], lane_in[2][k], lane_in[1][k], lane_in[0][k]};
                    res.data[k] = it.lut_bits[sel];
                end
            end
            default:  res.data = fetch_net(it.in_a);
        endcase
        if (res.in_range && it.op != OP_READ)
            net_shadow[it.net] = res.data;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t want;

        if (!rst_n)
        begin
            foreach (net_shadow[i])
                net_shadow[i] = '0;
            nets_used = NETS_USED_RST;
            rsp_due.delete();
            errors = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == NETS_USED_ADDR)
                nets_used = pwdata[CNT_W-1:0];
            if (req_valid && req_ready)
                rsp_due.insert(rsp_due.size(), eval_net_item(req));
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: response transfer with nothing outstanding: data %h in_range %0b",
                                 $time, rsp.data, rsp.in_range);
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (rsp.data !== want.data || rsp.in_range !== want.in_range)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: expected data %h in_range %0b, got data %h in_range %0b",
                                     $time, want.data, want.in_range, rsp.data, rsp.in_range);
                    end
                end
            end
        end
        pending = rsp_due.size();
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import lnee_pkg::*;

    localparam int ITEMS_PER_PHASE = 150;
    localparam int PHASES = 9;
    localparam logic [PADDR_W-1:0] NETS_USED_ADDR = PADDR_W'(4 * int'(REG_NETS_USED));

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    req_item_t          req;
    logic               rsp_valid;
    logic               rsp_ready;
    rsp_item_t          rsp;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int unsigned        errors;
    int unsigned        pending;

    logic [CNT_W-1:0]   nets_used_cfg;
    logic [CNT_W-1:0]   phase_counts [PHASES] = '{13'd4096, 13'd8191, 13'd16, 13'd1, 13'd0,
                                                  13'd2730, 13'd5461, 13'd4095, 13'd4096};
    bit                 req_quiet;
    int unsigned        req_left;
    bit                 rsp_quiet;
    int unsigned        rsp_left;

    lut4_net_evaluation_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    lnee_net_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("lut4_net_evaluation_engine_core regression: fail");
        $finish;
    end

    // idle stretches come in runs of 32 items, about a quarter of them with no idling
    function automatic int unsigned draw_wait(inout bit quiet, inout int unsigned left);
        if (left == 0)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            left = 32;
        end
        left--;
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic logic [NET_W-1:0] pick_net();
        int top;
        int v;

        top = (nets_used_cfg > NETS_DEF) ? NETS_DEF : int'(nets_used_cfg);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return NET_W'($urandom_range(0, 15));
            6, 7:
            begin
                // straddle the in-use limit
                v = top + int'($urandom_range(0, 3)) - 2;
                if (v < 0)
                    v = 0;
                if (v > NETS_DEF - 1)
                    v = NETS_DEF - 1;
                return NET_W'(v);
            end
            8:       return NET_W'(NETS_DEF - 1 - $urandom_range(0, 1));
            default: return NET_W'($urandom_range(0, NETS_DEF - 1));
        endcase
    endfunction

    function automatic req_item_t make_item(logic [1:0] op, int net, logic [DATA_W-1:0] value,
                                            logic [TT_W-1:0] tt, int cnt,
                                            int a, int b, int c, int d);
        req_item_t it;

        it.op = op;
        it.net = NET_W'(net);
        it.value = value;
        it.lut_bits = tt;
        it.input_count = ICNT_W'(cnt);
        it.in_a = NET_W'(a);
        it.in_b = NET_W'(b);
        it.in_c = NET_W'(c);
        it.in_d = NET_W'(d);
        return it;
    endfunction

    function automatic req_item_t random_item();
        req_item_t   it;
        int unsigned r;

        r = $urandom_range(0, 19);
        if (r < 5)
            it.op = OP_WRITE;
        else if (r < 9)
            it.op = OP_READ;
        else if (r < 16)
            it.op = OP_LUT;
        else
            it.op = OP_FF;
        it.net = pick_net();
        case ($urandom_range(0, 9))
            0:       it.value = '0;
            1:       it.value = '1;
            default: it.value = $urandom;
        endcase
        if ($urandom_range(0, 7) == 0)
            it.lut_bits = $urandom_range(0, 1) ? '1 : '0;
        else
            it.lut_bits = TT_W'($urandom);
        it.input_count = ICNT_W'($urandom_range(0, 7));
        it.in_a = pick_net();
        it.in_b = pick_net();
        it.in_c = pick_net();
        it.in_d = pick_net();
        return it;
    endfunction

    // called and returns at a falling edge
    task automatic push_item(input req_item_t it);
        int unsigned gap;

        gap = draw_wait(req_quiet, req_left);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic finish_phase();
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic set_nets_used(input logic [CNT_W-1:0] cnt);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= NETS_USED_ADDR;
        // bits above the register field carry noise
        pwdata <= (PDATA_W'($urandom) << CNT_W) | PDATA_W'(cnt);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        nets_used_cfg = cnt;
    endtask

    task automatic run_directed();
        push_item(make_item(OP_WRITE, 0, 32'hFFFF_FFFF, '0, 0, 0, 0, 0, 0));
        push_item(make_item(OP_WRITE, 4095, 32'hA5C3_5A3C, '0, 0, 0, 0, 0, 0));
        push_item(make_item(OP_READ, 4095, '0, '0, 0, 0, 0, 0, 0));
        push_item(make_item(OP_READ, 0, '0, '0, 0, 0, 0, 0, 0));
        // four inputs that together walk all sixteen table rows across the lanes
        push_item(make_item(OP_WRITE, 1, 32'h00FF_00FF, '0, 0, 0, 0, 0, 0));
        push_item(make_item(OP_WRITE, 2, 32'h0F0F_0F0F, '0, 0, 0, 0, 0, 0));
        push_item(make_item(OP_WRITE, 3, 32'h3333_3333, '0, 0, 0, 0, 0, 0));
        push_item(make_item(OP_WRITE, 4, 32'h5555_5555, '0, 0, 0, 0, 0, 0));
        push_item(make_item(OP_LUT, 10, '0, 16'h8000, 4, 4, 3, 2, 1));
        push_item(make_item(OP_LUT, 11, '0, 16'h6996, 4, 4, 3, 2, 1));
        push_item(make_item(OP_LUT, 12, '0, 16'hB38E, 4, 4, 3, 2, 1));
        // no inputs given: all four come from net 0
        push_item(make_item(OP_LUT, 13, '0, 16'h8001, 0, 4, 3, 2, 1));
        push_item(make_item(OP_LUT, 14, '0, 16'h8001, 1, 4, 3, 2, 1));
        push_item(make_item(OP_LUT, 15, '0, 16'h6996, 2, 4, 3, 2, 1));
        push_item(make_item(OP_LUT, 16, '0, 16'hFFFE, 3, 4, 3, 2, 1));
        // input counts past four behave as four
        push_item(make_item(OP_LUT, 17, '0, 16'h8000, 7, 4, 3, 2, 1));
        push_item(make_item(OP_LUT, 18, '0, 16'hFFFF, 5, 4, 3, 2, 1));
        push_item(make_item(OP_LUT, 19, '0, 16'h0000, 6, 4, 3, 2, 1));
        push_item(make_item(OP_FF, 21, '0, '0, 0, 12, 0, 0, 0));
        push_item(make_item(OP_FF, 4094, '0, '0, 0, 4095, 0, 0, 0));
        push_item(make_item(OP_READ, 4094, '0, '0, 0, 0, 0, 0, 0));
        // back to back dependence on the latest results
        push_item(make_item(OP_LUT, 4095, '0, 16'hA5A5, 4, 10, 11, 12, 13));
        push_item(make_item(OP_WRITE, 22, 32'h1357_9BDF, '0, 0, 0, 0, 0, 0));
        push_item(make_item(OP_FF, 22, '0, '0, 0, 22, 0, 0, 0));
        push_item(make_item(OP_READ, 22, '0, '0, 0, 0, 0, 0, 0));
    endtask

    // response side: stall for a drawn number of cycles after each transfer
    initial
    begin
        int unsigned stall;

        rsp_ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        rsp_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                stall = draw_wait(rsp_quiet, rsp_left);
                if (stall != 0)
                begin
                    @(negedge clk);
                    rsp_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                    rsp_ready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        nets_used_cfg = NETS_USED_RST;
        req_left = 0;
        rsp_left = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        finish_phase();
        for (int p = 0; p < PHASES; p++)
        begin
            set_nets_used(phase_counts[p]);
            repeat (ITEMS_PER_PHASE) push_item(random_item());
            finish_phase();
        end
        repeat (20) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("lut4_net_evaluation_engine_core regression: pass");
        else
            $display("lut4_net_evaluation_engine_core regression: fail");
        $finish;
    end

endmodule
